[rtl/core/skin_mask_ycbcr_box_blur_assert.svh]
// ---------------------------------------------------------------------------
// skin mask assertion macros
// concurrent checks clocked on clk, held off while arst_n is low
// ---------------------------------------------------------------------------
`ifndef SKIN_MASK_YCBCR_BOX_BLUR_ASSERT_SVH
`define SKIN_MASK_YCBCR_BOX_BLUR_ASSERT_SVH
`ifndef SYNTHESIS
// property that holds at every edge out of reset
`define SMBB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// property that must hold in the cycle after a trigger
`define SMBB_ASSERT_NEXT(lbl, trig, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (prop)) else $error(msg);
`else
`define SMBB_ASSERT(lbl, prop, msg)
`define SMBB_ASSERT_NEXT(lbl, trig, prop, msg)
`endif
`endif

[rtl/core/smbb_pkg.sv]
// ---------------------------------------------------------------------------
// smbb_pkg
// shared widths, coefficients and types of the skin mask block
// ---------------------------------------------------------------------------
`default_nettype none

package smbb_pkg;

	// image geometry
	localparam int MAX_W      = 1024;
	localparam int COL_W      = $clog2(MAX_W);
	localparam int AW_W       = 11;
	localparam int ROW_W      = 12;
	localparam int AH_W       = 13;
	localparam int HEIGHT_MAX = 4096;
	localparam int SLOT_W     = 2;
	localparam int CH_W       = 8;
	localparam int PIX_W      = 3 * CH_W;
	localparam int SUM_W      = 12;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_CB_MIN       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CB_MAX       = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CR_MIN       = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CR_MAX       = 3'd5;

	// input word commands
	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// fixed-point color conversion
	localparam int COEF_F = 14;
	localparam int K_R    = ((299 << COEF_F) + 500) / 1000;
	localparam int K_G    = ((587 << COEF_F) + 500) / 1000;
	localparam int K_B    = ((114 << COEF_F) + 500) / 1000;
	localparam int K_CR   = ((713 << COEF_F) + 500) / 1000;
	localparam int K_CB   = ((564 << COEF_F) + 500) / 1000;
	localparam int HALF   = 1 << (COEF_F - 1);
	localparam int C_OFFS = (128 << COEF_F) + HALF;

	// rounded divide by nine through a reciprocal
	localparam int DIV9_SHIFT = 16;
	localparam int DIV9_MUL   = ((1 << DIV9_SHIFT) + 8) / 9;

	// chroma acceptance window
	typedef struct packed {
		logic [CH_W-1:0] cb_min;
		logic [CH_W-1:0] cb_max;
		logic [CH_W-1:0] cr_min;
		logic [CH_W-1:0] cr_max;
	} chroma_bounds_t;

endpackage

`default_nettype wire

[rtl/core/smbb_pix_if.sv]
// ---------------------------------------------------------------------------
// smbb_pix_if
// input channel: pixel or flush word with valid/ready handshake
// ---------------------------------------------------------------------------
`default_nettype none

interface smbb_pix_if
	import smbb_pkg::*;
();
	logic            valid;
	logic            ready;
	logic            cmd;
	logic [CH_W-1:0] blue;
	logic [CH_W-1:0] green;
	logic [CH_W-1:0] red;

	modport source (output valid, cmd, blue, green, red, input ready);
	modport sink   (input valid, cmd, blue, green, red, output ready);
endinterface

`default_nettype wire

[rtl/core/smbb_res_if.sv]
// ---------------------------------------------------------------------------
// smbb_res_if
// output channel: skin flag and frame end mark with valid/ready handshake
// ---------------------------------------------------------------------------
`default_nettype none

interface smbb_res_if
	import smbb_pkg::*;
();
	logic valid;
	logic ready;
	logic skin;
	logic frame_end;

	modport source (output valid, skin, frame_end, input ready);
	modport sink   (input valid, skin, frame_end, output ready);
endinterface

`default_nettype wire

[rtl/core/smbb_chroma.sv]
// ---------------------------------------------------------------------------
// smbb_chroma
// five stage pipe: box average, luma, chroma, saturation and window test
// ---------------------------------------------------------------------------
`default_nettype none
`include "skin_mask_ycbcr_box_blur_assert.svh"

module smbb_chroma
	import smbb_pkg::*;
(
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 in_valid,
	input  wire     [SUM_W-1:0] sum_b,
	input  wire     [SUM_W-1:0] sum_g,
	input  wire     [SUM_W-1:0] sum_r,
	input  chroma_bounds_t      bounds,
	output logic                out_valid,
	output logic                skin
);

	localparam int DIV_W  = SUM_W + DIV9_SHIFT - 2;
	localparam int LUMA_W = CH_W + COEF_F;
	localparam int CHR_W  = CH_W + COEF_F + 3;
	localparam logic signed [CHR_W-1:0] KS_CR  = CHR_W'(K_CR);
	localparam logic signed [CHR_W-1:0] KS_CB  = CHR_W'(K_CB);
	localparam logic signed [CHR_W-1:0] OFFS_S = CHR_W'(C_OFFS);

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [CH_W-1:0] b_s1, g_s1, r_s1;
	logic [LUMA_W-1:0] pr_s2, pg_s2, pb_s2;
	logic [CH_W-1:0] r_s2, b_s2;
	logic [CH_W-1:0] y_s3, r_s3, b_s3;
	logic signed [CHR_W-1:0] pcr_s4, pcb_s4;
	logic skin_s5;

	logic [DIV_W-1:0] qb, qg, qr;
	logic [LUMA_W-1:0] ysum;
	logic signed [CH_W:0] dr, db;
	logic signed [CHR_W-1:0] tcr, tcb;
	logic [CH_W-1:0] cr_sat, cb_sat;

	// average of nine, rounded: (s + 4) * ceil(2^16 / 9) >> 16
	assign qb = (DIV_W'(sum_b) + DIV_W'(4)) * DIV_W'(DIV9_MUL);
	assign qg = (DIV_W'(sum_g) + DIV_W'(4)) * DIV_W'(DIV9_MUL);
	assign qr = (DIV_W'(sum_r) + DIV_W'(4)) * DIV_W'(DIV9_MUL);

	// luma sum with rounding
	assign ysum = pr_s2 + pg_s2 + pb_s2 + LUMA_W'(HALF);

	// color differences against luma
	assign dr = $signed({1'b0, r_s3}) - $signed({1'b0, y_s3});
	assign db = $signed({1'b0, b_s3}) - $signed({1'b0, y_s3});

	// offset and floor shift, then clamp to a byte
	assign tcr = pcr_s4 + OFFS_S;
	assign tcb = pcb_s4 + OFFS_S;

	always_comb begin
		if (tcr[CHR_W-1])
			cr_sat = '0;
		else if (|tcr[CHR_W-2:COEF_F+CH_W])
			cr_sat = '1;
		else
			cr_sat = tcr[COEF_F +: CH_W];
		if (tcb[CHR_W-1])
			cb_sat = '0;
		else if (|tcb[CHR_W-2:COEF_F+CH_W])
			cb_sat = '1;
		else
			cb_sat = tcb[COEF_F +: CH_W];
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// stage data
	always_ff @(posedge clk) begin
		b_s1   <= qb[DIV9_SHIFT +: CH_W];
		g_s1   <= qg[DIV9_SHIFT +: CH_W];
		r_s1   <= qr[DIV9_SHIFT +: CH_W];
		pr_s2  <= LUMA_W'(r_s1) * LUMA_W'(K_R);
		pg_s2  <= LUMA_W'(g_s1) * LUMA_W'(K_G);
		pb_s2  <= LUMA_W'(b_s1) * LUMA_W'(K_B);
		r_s2   <= r_s1;
		b_s2   <= b_s1;
		y_s3   <= ysum[COEF_F +: CH_W];
		r_s3   <= r_s2;
		b_s3   <= b_s2;
		pcr_s4 <= CHR_W'(dr) * KS_CR;
		pcb_s4 <= CHR_W'(db) * KS_CB;
		skin_s5 <= (cb_sat >= bounds.cb_min) && (cb_sat <= bounds.cb_max)
			&& (cr_sat >= bounds.cr_min) && (cr_sat <= bounds.cr_max);
	end

	assign out_valid = v_s5;
	assign skin      = skin_s5;

	// one word in flight at a time
	`SMBB_ASSERT(a_single_word, $countones({v_s1, v_s2, v_s3, v_s4, v_s5}) <= 1, "chroma pipe overlap")
	`SMBB_ASSERT_NEXT(a_pipe_moves, in_valid, v_s1, "chroma pipe lost a word")
	`SMBB_ASSERT_NEXT(a_pipe_out, v_s4, out_valid, "chroma pipe result missing")

endmodule

`default_nettype wire

[rtl/core/skin_mask_ycbcr_box_blur.sv]
// ---------------------------------------------------------------------------
// skin_mask_ycbcr_box_blur
// 3x3 box blur of a BGR raster stream followed by a Cb/Cr skin test
// ---------------------------------------------------------------------------
// usage
//   pixel  : input words, cmd 0 carries a BGR pixel, cmd 1 is a flush tick.
//   result : one skin flag per pixel, frame_end set on a frame's last pixel.
//   wr_*   : register writes (frame size, chroma window), to be made by the
//            user only while idle; the block does not enforce this.
// the result for pixel q leaves with the input word of pixel q + width + 1;
// after the last pixel, width + 1 flush words (width for one-row frames)
// drain the tail. a pixel arriving with tail results still owed starts a
// new frame and those results are dropped. one word is worked at a time:
// accept, nine reads of the single-port line memory (one per cycle), sum,
// five chroma stages and write back if a result is due; a pixel with none
// skips to write back, and a flush owing nothing is only accepted.
// reset: registers return to 640x480 and the default window, position 0,0;
// the line memory is not cleared and needs no clearing pass.
// a stalled receiver holds the result register; the next word is still
// taken and worked until its result needs the register.
// ---------------------------------------------------------------------------
`default_nettype none
`include "skin_mask_ycbcr_box_blur_assert.svh"

module skin_mask_ycbcr_box_blur
	import smbb_pkg::*;
(
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  wr_en,
	input  wire [CFG_IDX_W-1:0]  wr_index,
	input  wire [CFG_DATA_W-1:0] wr_data,
	smbb_pix_if.sink             pixel,
	smbb_res_if.source           result
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_READ   = 5'b00010,
		ST_SUM    = 5'b00100,
		ST_CALC   = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	localparam int MEM_D = 4 * MAX_W;

	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		return (s == SLOT_W'(2)) ? '0 : s + SLOT_W'(1);
	endfunction

	function automatic logic [SLOT_W-1:0] slot_dec(input logic [SLOT_W-1:0] s);
		return (s == '0) ? SLOT_W'(2) : s - SLOT_W'(1);
	endfunction

	state_t state_q;

	// registers
	logic [AW_W-1:0] fw_q;
	logic [AH_W-1:0] fh_q;
	chroma_bounds_t  bounds_q;

	// frame position
	logic [AW_W-1:0]   act_w_q;
	logic [AH_W-1:0]   act_h_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [SLOT_W-1:0] row_slot_q;
	logic [COL_W-1:0]  out_col_q;
	logic [ROW_W-1:0]  out_row_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic [AW_W-1:0]   pend_q;

	// current word
	logic             is_pix_q;
	logic             emit_q;
	logic [PIX_W-1:0] pix_q;

	// window fetch
	logic [1:0]       ri_q, cj_q;
	logic             rv_s1, live_s1;
	logic [PIX_W-1:0] rd_s1;
	logic [SUM_W-1:0] acc_b_q, acc_g_q, acc_r_q;
	logic             skin_res_q;

	// result register
	logic out_valid_q, out_skin_q, out_end_q;

	logic [PIX_W-1:0] line_mem [0:MEM_D-1];

	logic in_acc, in_pix, start_frame, emit_now;
	logic [AW_W-1:0] cw;
	logic [AH_W-1:0] ch;
	logic [ROW_W-1:0] rm, rp, frow;
	logic [COL_W-1:0] cm, cp, fcol;
	logic [SLOT_W-1:0] sm, sp, fslot;
	logic rp_ok, cp_ok, live_hit, read_end;
	logic [PIX_W-1:0] add_px;
	logic [SUM_W-1:0] sum_b, sum_g, sum_r;
	logic calc_v, calc_skin;
	logic out_free, fin_go, mem_we, mem_re, last_px;
	logic [AW_W-1:0] col_next;
	logic [AH_W-1:0] row_next;

	// input handshake and what the word asks for
	assign pixel.ready = (state_q == ST_IDLE);
	assign in_acc      = pixel.valid && pixel.ready;
	assign in_pix      = (pixel.cmd == CMD_PIXEL);
	assign start_frame = (row_q == '0) && (col_q == '0);
	assign emit_now    = in_pix ? ((row_q > ROW_W'(1)) || ((row_q == ROW_W'(1)) && (col_q != '0)))
		: (pend_q != '0);

	// frame size as used, clamped to the supported range
	always_comb begin
		if (fw_q == '0)
			cw = AW_W'(1);
		else if (fw_q > AW_W'(MAX_W))
			cw = AW_W'(MAX_W);
		else
			cw = fw_q;
		if (fh_q == '0)
			ch = AH_W'(1);
		else if (fh_q > AH_W'(HEIGHT_MAX))
			ch = AH_W'(HEIGHT_MAX);
		else
			ch = fh_q;
	end

	// neighbor rows and columns with replicated borders
	assign rp_ok = ({1'b0, out_row_q} + AH_W'(1)) < act_h_q;
	assign cp_ok = ({1'b0, out_col_q} + AW_W'(1)) < act_w_q;
	assign rm = (out_row_q == '0) ? '0 : out_row_q - ROW_W'(1);
	assign rp = rp_ok ? out_row_q + ROW_W'(1) : out_row_q;
	assign sm = (out_row_q == '0) ? out_slot_q : slot_dec(out_slot_q);
	assign sp = rp_ok ? slot_inc(out_slot_q) : out_slot_q;
	assign cm = (out_col_q == '0) ? '0 : out_col_q - COL_W'(1);
	assign cp = cp_ok ? out_col_q + COL_W'(1) : out_col_q;

	always_comb begin
		case (ri_q)
			2'd0: begin
				frow  = rm;
				fslot = sm;
			end
			2'd2: begin
				frow  = rp;
				fslot = sp;
			end
			default: begin
				frow  = out_row_q;
				fslot = out_slot_q;
			end
		endcase
		case (cj_q)
			2'd0:    fcol = cm;
			2'd2:    fcol = cp;
			default: fcol = out_col_q;
		endcase
	end

	// the incoming pixel is not in memory yet, forward it
	assign live_hit = is_pix_q && (frow == row_q) && (fcol == col_q);
	assign read_end = (ri_q == 2'd2) && (cj_q == 2'd2);

	// running window sums
	assign add_px = live_s1 ? pix_q : rd_s1;
	assign sum_b  = acc_b_q + SUM_W'(add_px[0 +: CH_W]);
	assign sum_g  = acc_g_q + SUM_W'(add_px[CH_W +: CH_W]);
	assign sum_r  = acc_r_q + SUM_W'(add_px[2*CH_W +: CH_W]);

	smbb_chroma u_chroma (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (state_q == ST_SUM),
		.sum_b     (sum_b),
		.sum_g     (sum_g),
		.sum_r     (sum_r),
		.bounds    (bounds_q),
		.out_valid (calc_v),
		.skin      (calc_skin)
	);

	// finish step, write back and result load
	assign out_free = !out_valid_q || result.ready;
	assign fin_go   = (state_q == ST_FINISH) && (!emit_q || out_free);
	assign mem_we   = fin_go && is_pix_q;
	assign mem_re   = (state_q == ST_READ);
	assign last_px  = (({1'b0, out_row_q} + AH_W'(1)) == act_h_q)
		&& (({1'b0, out_col_q} + AW_W'(1)) == act_w_q);
	assign col_next = {1'b0, col_q} + AW_W'(1);
	assign row_next = {1'b0, row_q} + AH_W'(1);

	// line memory: three rows by slot, one access per cycle
	always_ff @(posedge clk) begin
		if (mem_we)
			line_mem[{row_slot_q, col_q}] <= pix_q;
		else if (mem_re)
			rd_s1 <= line_mem[{fslot, fcol}];
	end

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q            <= AW_W'(640);
			fh_q            <= AH_W'(480);
			bounds_q.cb_min <= CH_W'(77);
			bounds_q.cb_max <= CH_W'(127);
			bounds_q.cr_min <= CH_W'(133);
			bounds_q.cr_max <= CH_W'(173);
		end else if (wr_en) begin
			case (wr_index)
				REG_FRAME_WIDTH:  fw_q            <= wr_data[AW_W-1:0];
				REG_FRAME_HEIGHT: fh_q            <= wr_data[AH_W-1:0];
				REG_CB_MIN:       bounds_q.cb_min <= wr_data[CH_W-1:0];
				REG_CB_MAX:       bounds_q.cb_max <= wr_data[CH_W-1:0];
				REG_CR_MIN:       bounds_q.cr_min <= wr_data[CH_W-1:0];
				REG_CR_MAX:       bounds_q.cr_max <= wr_data[CH_W-1:0];
				default: ;
			endcase
		end
	end

	// sequencer and frame position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			act_w_q     <= AW_W'(640);
			act_h_q     <= AH_W'(480);
			col_q       <= '0;
			row_q       <= '0;
			row_slot_q  <= '0;
			out_col_q   <= '0;
			out_row_q   <= '0;
			out_slot_q  <= '0;
			pend_q      <= '0;
			is_pix_q    <= 1'b0;
			emit_q      <= 1'b0;
			ri_q        <= '0;
			cj_q        <= '0;
			rv_s1       <= 1'b0;
			live_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rv_s1   <= mem_re;
			live_s1 <= live_hit;
			// result register: loaded by the finish step, freed by the receiver
			if (fin_go && emit_q)
				out_valid_q <= 1'b1;
			else if (result.ready)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						is_pix_q <= in_pix;
						emit_q   <= emit_now;
						ri_q     <= '0;
						cj_q     <= '0;
						if (in_pix && start_frame) begin
							act_w_q    <= cw;
							act_h_q    <= ch;
							pend_q     <= '0;
							out_row_q  <= '0;
							out_col_q  <= '0;
							out_slot_q <= '0;
						end
						if (emit_now)
							state_q <= ST_READ;
						else if (in_pix)
							state_q <= ST_FINISH;
					end
				end
				ST_READ: begin
					if (cj_q == 2'd2) begin
						cj_q <= '0;
						ri_q <= ri_q + 2'd1;
					end else begin
						cj_q <= cj_q + 2'd1;
					end
					if (read_end)
						state_q <= ST_SUM;
				end
				ST_SUM: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (calc_v)
						state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (fin_go) begin
						state_q <= ST_IDLE;
						if (emit_q) begin
							if (!is_pix_q)
								pend_q <= pend_q - AW_W'(1);
							if (last_px) begin
								out_row_q  <= '0;
								out_col_q  <= '0;
								out_slot_q <= '0;
							end else if (!cp_ok) begin
								out_col_q  <= '0;
								out_row_q  <= out_row_q + ROW_W'(1);
								out_slot_q <= slot_inc(out_slot_q);
							end else begin
								out_col_q <= out_col_q + COL_W'(1);
							end
						end
						if (is_pix_q) begin
							if (col_next >= act_w_q) begin
								col_q <= '0;
								if (row_next >= act_h_q) begin
									row_q      <= '0;
									row_slot_q <= '0;
									pend_q     <= (act_h_q == AH_W'(1)) ? act_w_q
										: act_w_q + AW_W'(1);
								end else begin
									row_q      <= row_next[ROW_W-1:0];
									row_slot_q <= slot_inc(row_slot_q);
								end
							end else begin
								col_q <= col_next[COL_W-1:0];
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// word payload, window sums and result data
	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_q   <= {pixel.red, pixel.green, pixel.blue};
			acc_b_q <= '0;
			acc_g_q <= '0;
			acc_r_q <= '0;
		end else if (rv_s1) begin
			acc_b_q <= sum_b;
			acc_g_q <= sum_g;
			acc_r_q <= sum_r;
		end
		if (calc_v)
			skin_res_q <= calc_skin;
		if (fin_go && emit_q) begin
			out_skin_q <= skin_res_q;
			out_end_q  <= last_px;
		end
	end

	assign result.valid     = out_valid_q;
	assign result.skin      = out_skin_q;
	assign result.frame_end = out_end_q;

	`SMBB_ASSERT(a_col_range, {1'b0, col_q} < act_w_q, "input column past frame width")
	`SMBB_ASSERT(a_row_range, {1'b0, row_q} < act_h_q, "input row past frame height")
	`SMBB_ASSERT_NEXT(a_finish_waits, (state_q == ST_FINISH) && emit_q && out_valid_q && !result.ready, (state_q == ST_FINISH) && out_valid_q, "result register overwritten")
	`SMBB_ASSERT_NEXT(a_calc_done, (state_q == ST_CALC) && calc_v, state_q == ST_FINISH, "chroma result not taken")

endmodule

`default_nettype wire

[tb/sv/tb_skin_mask_ycbcr_box_blur.sv]
// ---------------------------------------------------------------------------
// tb_skin_mask_ycbcr_box_blur
// self-checking bench: a blur and chroma predictor scores every skin flag and
// frame end mark against words driven at random pace with random back-pressure
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_skin_mask_ycbcr_box_blur;
	import smbb_pkg::*;

	// predicts the skin mask stream from accepted words
	class skin_scoreboard;
		localparam longint KR  = ((299 << 14) + 500) / 1000;
		localparam longint KG  = ((587 << 14) + 500) / 1000;
		localparam longint KB  = ((114 << 14) + 500) / 1000;
		localparam longint KCR = ((713 << 14) + 500) / 1000;
		localparam longint KCB = ((564 << 14) + 500) / 1000;

		bit [23:0]   rows [3][MAX_W];
		int unsigned width_reg, height_reg;
		bit [7:0]    cb_lo, cb_hi, cr_lo, cr_hi;
		int unsigned col, row, owed, act_w, act_h, out_row, out_col;
		bit [23:0]   live;
		bit          live_ok;
		bit [1:0]    mask_queue [$];
		int          errors;

		function new();
			width_reg = 640; height_reg = 480;
			cb_lo = 77; cb_hi = 127; cr_lo = 133; cr_hi = 173;
			col = 0; row = 0; owed = 0; out_row = 0; out_col = 0;
			live_ok = 0; errors = 0;
			latch_size();
		endfunction

		function void latch_size();
			act_w = (width_reg == 0) ? 1 : (width_reg > MAX_W ? MAX_W : width_reg);
			act_h = (height_reg == 0) ? 1 : (height_reg > 4096 ? 4096 : height_reg);
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
			case (idx)
				REG_FRAME_WIDTH:  width_reg = val & 'h7FF;
				REG_FRAME_HEIGHT: height_reg = val & 'h1FFF;
				REG_CB_MIN:       cb_lo = val[7:0];
				REG_CB_MAX:       cb_hi = val[7:0];
				REG_CR_MIN:       cr_lo = val[7:0];
				REG_CR_MAX:       cr_hi = val[7:0];
				default: ;
			endcase
		endfunction

		function bit [23:0] tap(int unsigned r, int unsigned c);
			if (live_ok && r == row && c == col) return live;
			if (c >= MAX_W) return 0;
			return rows[r % 3][c];
		endfunction

		function int unsigned chroma(longint diff, longint k);
			longint t;
			t = (diff * k + (128 <<< 14) + 8192) >>> 14;
			if (t < 0) t = 0;
			if (t > 255) t = 255;
			return int'(t);
		endfunction

		// blur the window around the output position and classify it
		function void blur_and_classify();
			int unsigned rs [3], cs [3], sb, sg, sr, b, g, rd, cb, cr;
			longint      y;
			bit [23:0]   p;
			bit          last;
			rs[0] = out_row > 0 ? out_row - 1 : 0;
			rs[1] = out_row;
			rs[2] = (out_row + 1 < act_h) ? out_row + 1 : out_row;
			cs[0] = out_col > 0 ? out_col - 1 : 0;
			cs[1] = out_col;
			cs[2] = (out_col + 1 < act_w) ? out_col + 1 : out_col;
			sb = 0; sg = 0; sr = 0;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					p = tap(rs[i], cs[j]);
					sb += p[7:0]; sg += p[15:8]; sr += p[23:16];
				end
			end
			b = (sb + 4) / 9; g = (sg + 4) / 9; rd = (sr + 4) / 9;
			y = (KR * rd + KG * g + KB * b + 8192) >>> 14;
			cr = chroma(longint'(rd) - y, KCR);
			cb = chroma(longint'(b) - y, KCB);
			last = (out_row + 1 == act_h) && (out_col + 1 == act_w);
			mask_queue.push_back({cb >= cb_lo && cb <= cb_hi && cr >= cr_lo && cr <= cr_hi,
				last});
			if (last) begin
				out_row = 0; out_col = 0;
			end else if (out_col + 1 >= act_w) begin
				out_col = 0; out_row++;
			end else begin
				out_col++;
			end
		endfunction

		// accepted input word
		function void note_word(bit cmd, bit [7:0] b, bit [7:0] g, bit [7:0] r);
			if (cmd == CMD_PIXEL) begin
				if (row == 0 && col == 0) begin
					latch_size();
					owed = 0; out_row = 0; out_col = 0;
				end
				if (row > 1 || (row == 1 && col >= 1)) begin
					live_ok = 1; live = {r, g, b};
					blur_and_classify();
					live_ok = 0;
				end
				if (col < MAX_W) rows[row % 3][col] = {r, g, b};
				col++;
				if (col >= act_w) begin
					col = 0; row++;
					if (row >= act_h) begin
						row = 0;
						owed = (act_h == 1) ? act_w : act_w + 1;
					end
				end
			end else if (owed > 0) begin
				blur_and_classify();
				owed--;
			end
		endfunction

		task report(string what);
			$display("mismatch at %0t: %s", $time, what);
			errors++;
		endtask

		// accepted result word
		task check_mask(bit skin, bit frame_end);
			bit [1:0] want;
			if (mask_queue.size() == 0) begin
				report($sformatf("unexpected word skin=%0b frame_end=%0b", skin, frame_end));
			end else begin
				want = mask_queue.pop_front();
				if (skin !== want[1])
					report($sformatf("skin %0b, predicted %0b", skin, want[1]));
				if (frame_end !== want[0])
					report($sformatf("frame_end %0b, predicted %0b", frame_end, want[0]));
			end
		endtask
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  wr_en;
	logic [CFG_IDX_W-1:0]  wr_index;
	logic [CFG_DATA_W-1:0] wr_data;
	bit                    calm;
	skin_scoreboard        sb;

	smbb_pix_if pixel ();
	smbb_res_if result ();

	skin_mask_ycbcr_box_blur DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.pixel    (pixel.sink),
		.result   (result.source)
	);

	// clock
	always begin
		clk = 1'b1; #1;
		clk = 1'b0; #1;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		result.ready <= calm || ($urandom_range(99) >= 20);
	end

	// score both channels
	always @(posedge clk) begin
		if (result.valid && result.ready) sb.check_mask(result.skin, result.frame_end);
		if (pixel.valid && pixel.ready) sb.note_word(pixel.cmd, pixel.blue, pixel.green,
			pixel.red);
	end

	task automatic put_word(bit cmd, bit [7:0] b, bit [7:0] g, bit [7:0] r);
		@(negedge clk);
		while (!calm && $urandom_range(99) < 20) begin
			pixel.valid <= 1'b0;
			@(negedge clk);
		end
		pixel.valid <= 1'b1;
		pixel.cmd   <= cmd;
		pixel.blue  <= b;
		pixel.green <= g;
		pixel.red   <= r;
		do @(posedge clk); while (!pixel.ready);
	endtask

	task automatic flush_word();
		put_word(CMD_FLUSH, 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	// wait for the block to go idle
	task automatic settle();
		@(negedge clk);
		pixel.valid <= 1'b0;
		while (sb.mask_queue.size() != 0) @(negedge clk);
		repeat (40) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val[CFG_DATA_W-1:0];
		sb.write_reg(idx, val);
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_window(int unsigned cbl, int unsigned cbh, int unsigned crl,
		int unsigned crh);
		write_reg(REG_CB_MIN, cbl);
		write_reg(REG_CB_MAX, cbh);
		write_reg(REG_CR_MIN, crl);
		write_reg(REG_CR_MAX, crh);
	endtask

	function automatic bit [7:0] jitter(int base, int spread);
		int v;
		v = base + $urandom_range(2 * spread) - spread;
		return 8'(v < 0 ? 0 : (v > 255 ? 255 : v));
	endfunction

	// one frame around a base color (or of corner colors), then tail flushes; tail < 0 drains fully
	task automatic send_frame(int unsigned w, int unsigned h, int spread, int tail,
		bit corners);
		int unsigned aw, ah, n;
		int          b0, g0, r0;
		aw = (w == 0) ? 1 : (w > MAX_W ? MAX_W : w);
		ah = (h == 0) ? 1 : (h > 4096 ? 4096 : h);
		b0 = $urandom_range(255); g0 = $urandom_range(255); r0 = $urandom_range(255);
		for (int unsigned k = 0; k < aw * ah; k++) begin
			// stray flush, with nothing owed once the frame has begun
			if ($urandom_range(99) < 3) flush_word();
			if (corners)
				put_word(CMD_PIXEL, k[0] ? 8'hFF : 8'h00, k[1] ? 8'hFF : 8'h00,
					k[2] ? 8'hFF : 8'h00);
			else
				put_word(CMD_PIXEL, jitter(b0, spread), jitter(g0, spread),
					jitter(r0, spread));
		end
		n = (tail < 0) ? ((ah == 1) ? aw : aw + 1) + $urandom_range(2) : tail;
		repeat (n) flush_word();
	endtask

	task automatic set_size(int unsigned w, int unsigned h);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
	endtask

	// end of run guard
	initial begin
		#3000000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int unsigned w, h, sent, spreads [3];
		sb = new();
		calm = 1'b0;
		arst_n = 1'b0;
		wr_en = 1'b0; wr_index = '0; wr_data = '0;
		pixel.valid = 1'b0; pixel.cmd = CMD_PIXEL;
		pixel.blue = '0; pixel.green = '0; pixel.red = '0;
		result.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: saturated channels, open window, ignored register indexes
		set_size(3, 3);
		set_window(0, 255, 0, 255);
		write_reg(3'd6, 13'h1FFF);
		write_reg(3'd7, 0);
		send_frame(3, 3, 0, -1, 1'b1);
		settle();
		// zero size acts as one pixel, empty chroma window
		set_size(0, 0);
		set_window(200, 10, 0, 255);
		send_frame(0, 0, 255, -1, 1'b0);
		settle();
		set_window(0, 255, 255, 0);
		send_frame(0, 0, 255, -1, 1'b0);
		settle();
		// default window; tail cut short by the next frame
		set_size(4, 2);
		set_window(77, 127, 133, 173);
		send_frame(4, 2, 40, 2, 1'b0);
		send_frame(4, 2, 40, -1, 1'b0);
		settle();

		// random frames, mostly small
		spreads = '{0, 12, 255};
		sent = 0;
		for (int f = 0; sent < 950; f++) begin
			calm = (f >= 20 && f < 30);
			settle();
			w = $urandom_range(1, 8);
			h = $urandom_range(1, 6);
			set_size(w, h);
			if ($urandom_range(3) == 0)
				set_window($urandom_range(255), $urandom_range(255), $urandom_range(255),
					$urandom_range(255));
			else
				set_window($urandom_range(60, 128), $urandom_range(120, 200),
					$urandom_range(100, 140), $urandom_range(130, 200));
			for (int k = 0; k < 3; k++) begin
				send_frame(w, h, spreads[$urandom_range(2)],
					(k < 2 && $urandom_range(5) == 0) ? $urandom_range(w) : -1, 1'b0);
				sent += w * h + w;
			end
		end
		calm = 1'b0;
		settle();

		if (sb.errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
